/* sv/vfac_pkg.sv */
package vfac_pkg;

	localparam int MAX_DIM_X = 128;
	localparam int MAX_DIM_Y = 128;
	localparam int MAX_DIM_Z = 1024;
	localparam int MAX_HALF  = 5;

	localparam int RING      = 2 * MAX_HALF + 1;
	localparam int NTAPS     = 11;
	localparam int TAP_W     = 16;
	localparam int SLOT_W    = 4;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 7;
	localparam int SLICE_W   = 10;
	localparam int ADDR_W    = SLOT_W + ROW_W + COL_W;
	localparam int MEM_DEPTH = RING * MAX_DIM_Y * MAX_DIM_X;
	localparam int PROD_W    = 48;
	localparam int ACC_W     = 52;
	localparam int RSH_W     = ACC_W - 14;

	localparam logic [3:0] REG_AXIS   = 4'd0;
	localparam logic [3:0] REG_DIM_X  = 4'd1;
	localparam logic [3:0] REG_DIM_Y  = 4'd2;
	localparam logic [3:0] REG_DIM_Z  = 4'd3;
	localparam logic [3:0] REG_HALF   = 4'd4;
	localparam logic [3:0] REG_TAPS_0 = 4'd5;
	localparam logic [3:0] REG_TAPS_4 = 4'd6;
	localparam logic [3:0] REG_TAPS_8 = 4'd7;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic signed [31:0] comp_x;
		logic signed [31:0] comp_y;
		logic signed [31:0] comp_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0]  out_x;
		logic signed [31:0]  out_y;
		logic signed [31:0]  out_z;
		logic [COL_W-1:0]    pos_col;
		logic [ROW_W-1:0]    pos_row;
		logic [SLICE_W-1:0]  pos_slice;
		logic                last_of_run;
	} out_t;

	typedef struct packed {
		logic [1:0]  ax;
		logic [7:0]  dx;
		logic [7:0]  dy;
		logic [10:0] dz;
		logic [2:0]  h;
	} cfg_t;

	typedef struct packed {
		in_t                vox;
		logic [SLOT_W-1:0]  pslot;
		logic [SLICE_W-1:0] p;
		logic [10:0]        n;
		logic               has;
		logic [SLICE_W-1:0] first;
		logic [SLICE_W-1:0] last;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [SLICE_W-1:0] slice;
		logic [1:0]         ax;
		logic [2:0]         h;
	} job_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} jq_stat_t;

	// Q22.30 sum to Q16.16, half up, saturated
	function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] v;
		logic signed [RSH_W-1:0] r;
		v = acc + ACC_W'(8192);
		r = v[ACC_W-1:14];
		if (r[RSH_W-1:31] != {(RSH_W-31){r[31]}})
			return r[RSH_W-1] ? 32'sh80000000 : 32'sh7fffffff;
		return r[31:0];
	endfunction

endpackage

/* sv/vector_field_axis_convolve_core.sv */
// One-axis FIR over a 3-component vector field streamed in raster order.
// Input queue side: drive item and push; a word is taken when full is low.
// Result queue side: result is valid while empty is low, pop takes it.
// Each result carries its voxel coordinates; last_of_run marks the final
// result caused by one input word (an input may cause none, or up to one
// more than the kernel half length at the far edge of the axis).
// Configuration: cfg_we/cfg_index/cfg_data, write only while idle; any
// write to a known register restarts the volume at (0,0,0).
// The front tracks position and classifies each word into a job, pushed
// into a two-entry job queue. The back runs one job at a time on a single
// history RAM port: it fetches the job, then stores the voxel; then for
// each result it reads, multiplies and accumulates each in-volume tap
// (S_TAP, S_MUL, S_ACC), passes over each skipped tap in S_TAP, and hands
// the result to the output register in S_OUT. A word with no result is
// done once its voxel is stored.
// Reset clears counters, queues and the output valid flag; history contents
// are not cleared. A stalled receiver holds the back in its output step
// while the front keeps taking words until the job queue fills.
module vector_field_axis_convolve_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [3:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic             push,
	input  vfac_pkg::in_t    item,
	output logic             full,
	input  logic             pop,
	output vfac_pkg::out_t   result,
	output logic             empty
);

	logic [1:0]  axis_q;
	logic [7:0]  dim_x_q, dim_y_q;
	logic [10:0] dim_z_q;
	logic [2:0]  half_q;
	logic [63:0] taps0_q, taps1_q;
	logic [47:0] taps2_q;

	vfac_pkg::cfg_t     cfg;
	vfac_pkg::job_t     fjob, hjob;
	vfac_pkg::jq_stat_t jq_stat;
	logic               restart, jpush, jpop;

	assign restart = cfg_we && (cfg_index <= vfac_pkg::REG_TAPS_8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= vfac_pkg::AX_X;
			dim_x_q <= 8'd128;
			dim_y_q <= 8'd128;
			dim_z_q <= 11'd128;
			half_q  <= 3'd1;
			taps0_q <= 64'd1073741824;
			taps1_q <= '0;
			taps2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vfac_pkg::REG_AXIS:   axis_q  <= cfg_data[1:0];
				vfac_pkg::REG_DIM_X:  dim_x_q <= cfg_data[7:0];
				vfac_pkg::REG_DIM_Y:  dim_y_q <= cfg_data[7:0];
				vfac_pkg::REG_DIM_Z:  dim_z_q <= cfg_data[10:0];
				vfac_pkg::REG_HALF:   half_q  <= cfg_data[2:0];
				vfac_pkg::REG_TAPS_0: taps0_q <= cfg_data;
				vfac_pkg::REG_TAPS_4: taps1_q <= cfg_data;
				vfac_pkg::REG_TAPS_8: taps2_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.ax = (axis_q == vfac_pkg::AX_Y || axis_q == vfac_pkg::AX_Z) ? axis_q
			: vfac_pkg::AX_X;
		cfg.dx = (dim_x_q == '0) ? 8'd1
			: (dim_x_q > 8'(vfac_pkg::MAX_DIM_X)) ? 8'(vfac_pkg::MAX_DIM_X) : dim_x_q;
		cfg.dy = (dim_y_q == '0) ? 8'd1
			: (dim_y_q > 8'(vfac_pkg::MAX_DIM_Y)) ? 8'(vfac_pkg::MAX_DIM_Y) : dim_y_q;
		cfg.dz = (dim_z_q == '0) ? 11'd1
			: (dim_z_q > 11'(vfac_pkg::MAX_DIM_Z)) ? 11'(vfac_pkg::MAX_DIM_Z) : dim_z_q;
		cfg.h  = (half_q > 3'(vfac_pkg::MAX_HALF)) ? 3'(vfac_pkg::MAX_HALF) : half_q;
	end

	vfac_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.push    (push),
		.item    (item),
		.full    (full),
		.jq_full (jq_stat.full),
		.jpush   (jpush),
		.job     (fjob)
	);

	vfac_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (jpush),
		.wdata  (fjob),
		.rd     (jpop),
		.rdata  (hjob),
		.stat   (jq_stat)
	);

	vfac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tap_bus  ({taps2_q, taps1_q, taps0_q}),
		.jq_empty (jq_stat.empty),
		.jq_head  (hjob),
		.jpop     (jpop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

`ifndef SYNTHESIS
	a_jq_flags: assert property (@(posedge clk) disable iff (!arst_n)
		jq_stat.full |-> !jq_stat.empty) else $error("job queue full and empty");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !jq_stat.empty) else $error("accepted word lost");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, result.pos_col} < cfg.dx)) else $error("column out of volume");
`endif

endmodule

/* sv/vfac_front.sv */
module vfac_front (
	input  logic              clk,
	input  logic              arst_n,
	input  vfac_pkg::cfg_t    cfg,
	input  logic              restart,
	input  logic              push,
	input  vfac_pkg::in_t     item,
	output logic              full,
	input  logic              jq_full,
	output logic              jpush,
	output vfac_pkg::job_t    job
);

	logic [vfac_pkg::COL_W-1:0]   col_q;
	logic [vfac_pkg::ROW_W-1:0]   row_q;
	logic [vfac_pkg::SLICE_W-1:0] slice_q;
	logic [vfac_pkg::SLOT_W-1:0]  cslot_q, rslot_q, sslot_q;

	logic [vfac_pkg::SLICE_W-1:0] p;
	logic [10:0]                  n;
	logic [vfac_pkg::SLOT_W-1:0]  pslot;
	logic                         at_end, ge_h;
	logic                         col_end, row_end, slice_end;

	assign full  = jq_full;
	assign jpush = push && !jq_full;

	always_comb begin
		unique case (cfg.ax)
			vfac_pkg::AX_Y: begin
				p = {3'b0, row_q}; n = {3'b0, cfg.dy}; pslot = rslot_q;
			end
			vfac_pkg::AX_Z: begin
				p = slice_q; n = cfg.dz; pslot = sslot_q;
			end
			default: begin
				p = {3'b0, col_q}; n = {3'b0, cfg.dx}; pslot = cslot_q;
			end
		endcase
	end

	assign at_end = {1'b0, p} == n - 11'd1;
	assign ge_h   = p >= {7'b0, cfg.h};

	always_comb begin
		job.vox   = item;
		job.pslot = pslot;
		job.p     = p;
		job.n     = n;
		job.first = ge_h ? p - {7'b0, cfg.h} : '0;
		job.has   = at_end || ge_h;
		job.last  = at_end ? p : p - {7'b0, cfg.h};
		job.col   = col_q;
		job.row   = row_q;
		job.slice = slice_q;
		job.ax    = cfg.ax;
		job.h     = cfg.h;
	end

	assign col_end   = {1'b0, col_q} == cfg.dx - 8'd1;
	assign row_end   = {1'b0, row_q} == cfg.dy - 8'd1;
	assign slice_end = {1'b0, slice_q} == cfg.dz - 11'd1;

	function automatic logic [vfac_pkg::SLOT_W-1:0] slot_inc(input logic [vfac_pkg::SLOT_W-1:0] s);
		return (s == vfac_pkg::SLOT_W'(vfac_pkg::RING - 1)) ? '0 : s + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0; slice_q <= '0;
			cslot_q <= '0; rslot_q <= '0; sslot_q <= '0;
		end else if (restart) begin
			col_q <= '0; row_q <= '0; slice_q <= '0;
			cslot_q <= '0; rslot_q <= '0; sslot_q <= '0;
		end else if (jpush) begin
			if (col_end) begin
				col_q   <= '0;
				cslot_q <= '0;
				if (row_end) begin
					row_q   <= '0;
					rslot_q <= '0;
					if (slice_end) begin
						slice_q <= '0;
						sslot_q <= '0;
					end else begin
						slice_q <= slice_q + 1'b1;
						sslot_q <= slot_inc(sslot_q);
					end
				end else begin
					row_q   <= row_q + 1'b1;
					rslot_q <= slot_inc(rslot_q);
				end
			end else begin
				col_q   <= col_q + 1'b1;
				cslot_q <= slot_inc(cslot_q);
			end
		end
	end

endmodule

/* sv/vfac_jobq.sv */
module vfac_jobq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  vfac_pkg::job_t      wdata,
	input  logic                rd,
	output vfac_pkg::job_t      rdata,
	output vfac_pkg::jq_stat_t  stat
);

	vfac_pkg::job_t entry_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     cnt_q;

	assign rdata      = entry_q[rptr_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
	assign stat.count = cnt_q;

	always_ff @(posedge clk) begin
		if (wr)
			entry_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= ~wptr_q;
			if (rd)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

/* sv/vfac_back.sv */
module vfac_back (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [vfac_pkg::NTAPS*vfac_pkg::TAP_W-1:0] tap_bus,
	input  logic                                    jq_empty,
	input  vfac_pkg::job_t                          jq_head,
	output logic                                    jpop,
	output logic                                    empty,
	input  logic                                    pop,
	output vfac_pkg::out_t                          result
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_WR   = 6'b000010,
		S_TAP  = 6'b000100,
		S_MUL  = 6'b001000,
		S_ACC  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t                             state_q;
	vfac_pkg::job_t                     job_q;
	logic [vfac_pkg::SLICE_W-1:0]       q_q;
	logic [3:0]                         k_q;
	logic signed [vfac_pkg::ACC_W-1:0]  acc_x_q, acc_y_q, acc_z_q;
	logic signed [vfac_pkg::PROD_W-1:0] prod_x_q, prod_y_q, prod_z_q;
	vfac_pkg::in_t                      mem [vfac_pkg::MEM_DEPTH];
	vfac_pkg::in_t                      rdata_s1;
	vfac_pkg::out_t                     res_q;
	logic                               ovalid_q;

	logic signed [12:0]                 t;
	logic signed [12:0]                 dd;
	logic [vfac_pkg::SLOT_W-1:0]        d, tslot, slot;
	logic                               tap_ok, k_done, out_go, q_done;
	logic [vfac_pkg::ROW_W-1:0]         a;
	logic [vfac_pkg::COL_W-1:0]         b;
	logic [vfac_pkg::ADDR_W-1:0]        addr;
	logic signed [vfac_pkg::TAP_W-1:0]  tap;

	assign t = $signed({3'b0, q_q}) - $signed({10'b0, job_q.h}) + $signed({9'b0, k_q});
	assign tap_ok = (t >= 0) && (t < $signed({2'b0, job_q.n})) && (t <= $signed({3'b0, job_q.p}));
	assign dd = $signed({3'b0, job_q.p}) - t;
	assign d  = dd[vfac_pkg::SLOT_W-1:0];
	// ring slot of t, counted back from the slot of the newest voxel
	assign tslot = (job_q.pslot >= d) ? job_q.pslot - d
		: job_q.pslot + vfac_pkg::SLOT_W'(vfac_pkg::RING) - d;
	assign slot = (state_q == S_WR) ? job_q.pslot : tslot;

	assign a = (job_q.ax == vfac_pkg::AX_Z) ? job_q.row : '0;
	assign b = (job_q.ax == vfac_pkg::AX_Y || job_q.ax == vfac_pkg::AX_Z) ? job_q.col : '0;
	assign addr = {slot, a, b};

	assign tap    = $signed(tap_bus[k_q*vfac_pkg::TAP_W +: vfac_pkg::TAP_W]);
	assign k_done = k_q == {job_q.h, 1'b0};
	assign out_go = !ovalid_q || pop;
	assign q_done = q_q == job_q.last;
	assign jpop   = (state_q == S_IDLE) && !jq_empty;

	assign empty  = !ovalid_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (state_q == S_WR)
			mem[addr] <= job_q.vox;
		rdata_s1 <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (jpop)
			job_q <= jq_head;
		prod_x_q <= rdata_s1.comp_x * tap;
		prod_y_q <= rdata_s1.comp_y * tap;
		prod_z_q <= rdata_s1.comp_z * tap;
		if (state_q == S_OUT && out_go) begin
			res_q.out_x       <= vfac_pkg::round_sat(acc_x_q);
			res_q.out_y       <= vfac_pkg::round_sat(acc_y_q);
			res_q.out_z       <= vfac_pkg::round_sat(acc_z_q);
			res_q.pos_col     <= (job_q.ax == vfac_pkg::AX_X) ? q_q[vfac_pkg::COL_W-1:0]
				: job_q.col;
			res_q.pos_row     <= (job_q.ax == vfac_pkg::AX_Y) ? q_q[vfac_pkg::ROW_W-1:0]
				: job_q.row;
			res_q.pos_slice   <= (job_q.ax == vfac_pkg::AX_Z) ? q_q : job_q.slice;
			res_q.last_of_run <= q_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			q_q      <= '0;
			k_q      <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			acc_z_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_go)
				ovalid_q <= 1'b1;
			else if (pop && ovalid_q)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!jq_empty)
						state_q <= S_WR;
				end
				S_WR: begin
					q_q     <= job_q.first;
					k_q     <= '0;
					acc_x_q <= '0;
					acc_y_q <= '0;
					acc_z_q <= '0;
					state_q <= job_q.has ? S_TAP : S_IDLE;
				end
				S_TAP: begin
					if (tap_ok)
						state_q <= S_MUL;
					else if (k_done)
						state_q <= S_OUT;
					else
						k_q <= k_q + 1'b1;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_x_q <= acc_x_q + vfac_pkg::ACC_W'(prod_x_q);
					acc_y_q <= acc_y_q + vfac_pkg::ACC_W'(prod_y_q);
					acc_z_q <= acc_z_q + vfac_pkg::ACC_W'(prod_z_q);
					if (k_done) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_TAP;
					end
				end
				S_OUT: begin
					if (out_go) begin
						k_q      <= '0;
						acc_x_q  <= '0;
						acc_y_q  <= '0;
						acc_z_q  <= '0;
						if (q_done) begin
							state_q <= S_IDLE;
						end else begin
							q_q     <= q_q + 1'b1;
							state_q <= S_TAP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE = 300;
	localparam int RANDOM_ITEMS = 410;

	typedef struct {
		bit             is_cfg;
		logic [3:0]     idx;
		logic [63:0]    data;
		vfac_pkg::in_t  vox;
		bit             typed;
		vfac_pkg::out_t want;
	} row_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [3:0]     cfg_index;
	logic [63:0]    cfg_data;
	logic           push;
	vfac_pkg::in_t  item;
	logic           full;
	logic           pop;
	vfac_pkg::out_t result;
	logic           empty;

	vector_field_axis_convolve_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .item(item), .full(full),
		.pop(pop), .result(result), .empty(empty)
	);

	// shadow of the block's registers and position
	logic [1:0]  m_axis;
	logic [7:0]  m_dim_x, m_dim_y;
	logic [10:0] m_dim_z;
	logic [2:0]  m_half;
	logic [63:0] m_taps0, m_taps4;
	logic [47:0] m_taps8;
	int          cur_col, cur_row, cur_slice;
	logic signed [31:0] voxel_store [int];

	vfac_pkg::out_t pending_words[$];
	int    mismatches;
	int    items_sent;
	int    cycles;
	bit    quiet;
	int    pop_hold;

	function automatic longint tap_of(int k);
		logic [175:0] all;
		logic signed [15:0] t;
		all = {m_taps8, m_taps4, m_taps0};
		t = all[16*k +: 16];
		return longint'(t);
	endfunction

	function automatic logic signed [31:0] to_q16(longint acc);
		longint r;
		r = (acc + 64'sd8192) >>> 14;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic int store_key(int slot, int a, int b, int c);
		return ((slot * 128 + a) * 128 + b) * 3 + c;
	endfunction

	// filters one accepted voxel; appends the words it releases
	function automatic void filter_voxel(vfac_pkg::in_t v);
		int dx, dy, dz, h, ax, p, n, a, b, first, last, cnt, t, key;
		longint acc;
		longint sum[3];
		logic signed [31:0] comp[3];
		vfac_pkg::out_t r;
		dx = (m_dim_x == 0) ? 1
			: ((m_dim_x > vfac_pkg::MAX_DIM_X) ? vfac_pkg::MAX_DIM_X : m_dim_x);
		dy = (m_dim_y == 0) ? 1
			: ((m_dim_y > vfac_pkg::MAX_DIM_Y) ? vfac_pkg::MAX_DIM_Y : m_dim_y);
		dz = (m_dim_z == 0) ? 1
			: ((m_dim_z > vfac_pkg::MAX_DIM_Z) ? vfac_pkg::MAX_DIM_Z : m_dim_z);
		h = (m_half > vfac_pkg::MAX_HALF) ? vfac_pkg::MAX_HALF : m_half;
		ax = (m_axis == vfac_pkg::AX_Y || m_axis == vfac_pkg::AX_Z) ? m_axis
			: vfac_pkg::AX_X;
		comp[0] = v.comp_x;
		comp[1] = v.comp_y;
		comp[2] = v.comp_z;
		cnt = 0;
		if (cur_col >= dx) cur_col = 0;
		if (cur_row >= dy) cur_row = 0;
		if (cur_slice >= dz) cur_slice = 0;
		if (ax == vfac_pkg::AX_X) begin
			p = cur_col; n = dx; a = 0; b = 0;
		end else if (ax == vfac_pkg::AX_Y) begin
			p = cur_row; n = dy; a = 0; b = cur_col;
		end else begin
			p = cur_slice; n = dz; a = cur_row; b = cur_col;
		end
		for (int c = 0; c < 3; c++)
			voxel_store[store_key(p % vfac_pkg::RING, a, b, c)] = comp[c];
		first = (p >= h) ? p - h : 0;
		if (p == n - 1) last = p;
		else if (p >= h) last = p - h;
		else begin
			first = 1; last = 0;
		end
		for (int q = first; q <= last && q <= p; q++) begin
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int k = 0; k <= 2 * h; k++) begin
					t = q - h + k;
					if (t < 0 || t >= n || t > p) continue;
					key = store_key(t % vfac_pkg::RING, a, b, c);
					if (voxel_store.exists(key))
						acc += tap_of(k) * longint'(voxel_store[key]);
				end
				sum[c] = acc;
			end
			r.out_x = to_q16(sum[0]);
			r.out_y = to_q16(sum[1]);
			r.out_z = to_q16(sum[2]);
			r.pos_col = 7'((ax == vfac_pkg::AX_X) ? q : cur_col);
			r.pos_row = 7'((ax == vfac_pkg::AX_Y) ? q : cur_row);
			r.pos_slice = 10'((ax == vfac_pkg::AX_Z) ? q : cur_slice);
			r.last_of_run = 1'b0;
			pending_words.push_back(r);
			cnt++;
		end
		if (cnt > 0) pending_words[pending_words.size() - 1].last_of_run = 1'b1;
		cur_col++;
		if (cur_col >= dx) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= dy) begin
				cur_row = 0;
				cur_slice++;
				if (cur_slice >= dz) cur_slice = 0;
			end
		end
	endfunction

	function automatic void shadow_write(logic [3:0] idx, logic [63:0] d);
		case (idx)
			vfac_pkg::REG_AXIS:   m_axis = d[1:0];
			vfac_pkg::REG_DIM_X:  m_dim_x = d[7:0];
			vfac_pkg::REG_DIM_Y:  m_dim_y = d[7:0];
			vfac_pkg::REG_DIM_Z:  m_dim_z = d[10:0];
			vfac_pkg::REG_HALF:   m_half = d[2:0];
			vfac_pkg::REG_TAPS_0: m_taps0 = d;
			vfac_pkg::REG_TAPS_4: m_taps4 = d;
			vfac_pkg::REG_TAPS_8: m_taps8 = d[47:0];
			default: return;
		endcase
		cur_col = 0;
		cur_row = 0;
		cur_slice = 0;
	endfunction

	// wait for all words, then let a word-less job finish before touching registers
	task automatic drain();
		push <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [63:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_write(idx, d);
		@(posedge clk);
	endtask

	// push stays high after the accept; drain() or the next idle burst drops it
	task automatic send(vfac_pkg::in_t v);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push <= 1'b1;
		item <= v;
		do @(posedge clk); while (full);
		filter_voxel(v);
		items_sent++;
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			1: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] rand_taps();
		logic [63:0] t;
		for (int i = 0; i < 4; i++)
			t[16*i +: 16] = $urandom_range(0, 1) ? 16'($urandom)
				: 16'($urandom_range(0, 16384)) - 16'd8192;
		return t;
	endfunction

	function automatic vfac_pkg::in_t rand_vox();
		vfac_pkg::in_t v;
		v.comp_x = rand_comp();
		v.comp_y = rand_comp();
		v.comp_z = rand_comp();
		return v;
	endfunction

	task automatic run_phase(int ax, int dx, int dy, int dz, int h, int count);
		drain();
		write_reg(vfac_pkg::REG_AXIS, 64'(ax));
		write_reg(vfac_pkg::REG_DIM_X, 64'(dx));
		write_reg(vfac_pkg::REG_DIM_Y, 64'(dy));
		write_reg(vfac_pkg::REG_DIM_Z, 64'(dz));
		write_reg(vfac_pkg::REG_HALF, 64'(h));
		write_reg(vfac_pkg::REG_TAPS_0, rand_taps());
		write_reg(vfac_pkg::REG_TAPS_4, rand_taps());
		write_reg(vfac_pkg::REG_TAPS_8, $urandom_range(0, 1) ? 64'd0 : rand_taps());
		for (int i = 0; i < count; i++) begin
			if (items_sent > RANDOM_ITEMS - 80) quiet = 1'b1;
			send(rand_vox());
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// result side: check the word taken at this edge, then pick next pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %p", result);
				end else begin
					if (result !== pending_words[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p",
								pending_words[0], result);
					end
					void'(pending_words.pop_front());
				end
			end
			if (pop_hold > 0) begin
				pop_hold <= pop_hold - 1;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pop_hold <= $urandom_range(0, 6);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		row_t script[$];
		row_t r;
		vfac_pkg::in_t a0;
		int ax, dx, dy, dz, h, vol;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		item = '0;
		pop = 1'b0;
		pop_hold = 0;
		quiet = 1'b0;
		mismatches = 0;
		items_sent = 0;
		cycles = 0;
		arst_n = 1'b0;
		shadow_write(vfac_pkg::REG_AXIS, 64'(vfac_pkg::AX_X));
		m_dim_x = 8'd128; m_dim_y = 8'd128; m_dim_z = 11'd128; m_half = 3'd1;
		m_taps0 = 64'd1073741824; m_taps4 = '0; m_taps8 = '0;

		// reset kernel is identity on tap 1, half width 1 along x
		a0 = '{32'sh7fffffff, 32'sh80000000, 32'sh00000001};
		r = '{default: '0};
		r.vox = a0;
		script.push_back(r);
		r.vox = '{32'sh0, -32'sh1, 32'sh12345678};
		r.typed = 1;
		r.want = '{a0.comp_x, a0.comp_y, a0.comp_z, 7'd0, 7'd0, 10'd0, 1'b1};
		script.push_back(r);
		// single tap of -2.0: every extreme saturates
		r = '{default: '0};
		r.is_cfg = 1; r.idx = vfac_pkg::REG_HALF; r.data = 64'd0;
		script.push_back(r);
		r.idx = vfac_pkg::REG_TAPS_0; r.data = 64'h8000;
		script.push_back(r);
		r = '{default: '0};
		r.vox = a0;
		r.typed = 1;
		r.want = '{32'sh80000000, 32'sh7fffffff, -32'sh2, 7'd0, 7'd0, 10'd0, 1'b1};
		script.push_back(r);
		// axis three, zero dims, oversized half width
		r = '{default: '0};
		r.is_cfg = 1;
		r.idx = vfac_pkg::REG_AXIS; r.data = 64'd3; script.push_back(r);
		r.idx = vfac_pkg::REG_DIM_X; r.data = 64'd2; script.push_back(r);
		r.idx = vfac_pkg::REG_DIM_Y; r.data = 64'd0; script.push_back(r);
		r.idx = vfac_pkg::REG_DIM_Z; r.data = 64'd0; script.push_back(r);
		r.idx = vfac_pkg::REG_HALF; r.data = 64'd7; script.push_back(r);
		r.idx = vfac_pkg::REG_TAPS_0; r.data = rand_taps(); script.push_back(r);
		r.idx = vfac_pkg::REG_TAPS_4; r.data = rand_taps(); script.push_back(r);
		r.idx = vfac_pkg::REG_TAPS_8; r.data = rand_taps(); script.push_back(r);
		r = '{default: '0};
		for (int i = 0; i < 4; i++) begin
			r.vox = rand_vox();
			script.push_back(r);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				if (i == 0 || !script[i-1].is_cfg) drain();
				write_reg(script[i].idx, script[i].data);
			end else begin
				send(script[i].vox);
				if (script[i].typed) begin
					void'(pending_words.pop_back());
					pending_words.push_back(script[i].want);
				end
			end
		end

		// full-length flush along z, then y
		run_phase(vfac_pkg::AX_Z, 2, 1, 6, 5, 12);
		run_phase(vfac_pkg::AX_Y, 2, 3, 1, 1, 6);
		// dims past the maximum
		run_phase(vfac_pkg::AX_X, 255, 1, 1, $urandom_range(0, 5), 130);
		run_phase(vfac_pkg::AX_Y, 1, 255, 1, $urandom_range(0, 5), 130);
		run_phase(vfac_pkg::AX_Z, 1, 1, 2047, $urandom_range(0, 7), 30);
		while (items_sent < RANDOM_ITEMS - 30) begin
			ax = $urandom_range(0, 3);
			dx = $urandom_range(0, 8);
			dy = $urandom_range(0, 4);
			dz = $urandom_range(0, 6);
			h = $urandom_range(0, 7);
			vol = (dx == 0 ? 1 : dx) * (dy == 0 ? 1 : dy) * (dz == 0 ? 1 : dz);
			if (vol > 60) vol = 60;
			run_phase(ax, dx, dy, dz, h, vol + $urandom_range(0, 3));
		end

		drain();
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/vfac_pkg.sv
sv/vfac_front.sv
sv/vfac_jobq.sv
sv/vfac_back.sv
sv/vector_field_axis_convolve_core.sv
tb/sv/testbench.sv
